// ===== sv/mbtd_pkg.sv =====
// ----------------------------------------------------------------------------
// mbtd_pkg
// Shared constants and types for the multi-button time debouncer.
// ----------------------------------------------------------------------------
package mbtd_pkg;

    localparam int NUM_BUTTONS    = 9;
    localparam int BOOT_INDEX     = 8;
    localparam int NUM_REG_BITS   = 8;
    localparam int ANY_DOWN_COUNT = 7;    // UP..SELECT; SLIDE and BOOT excluded
    localparam int DEB_W          = 16;
    localparam int SEL_W          = 4;
    localparam int HELD_W         = 32;
    localparam int NOW_W          = 32;
    localparam int TIME_WIDTH_DEF = 32;

    localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 16'd12;

    // APB register map
    localparam int               ADDR_W       = 2;
    localparam int               PDATA_W      = 32;
    localparam logic [ADDR_W-1:0] ADDR_DEBOUNCE = 2'd0;

    // bit of the inverted register byte that feeds each button
    localparam logic [2:0] BIT_OF_BUTTON [NUM_REG_BITS] = '{
        3'd2, 3'd4, 3'd0, 3'd1, 3'd7, 3'd6, 3'd5, 3'd3
    };

    typedef struct packed {
        logic stable_next;
        logic pressed;
        logic released;
    } t_btn_status;

endpackage

// ===== sv/mbtd_btn.sv =====
// ----------------------------------------------------------------------------
// mbtd_btn
// One button: candidate tracking, debounce timer and press timestamp.
// ----------------------------------------------------------------------------
module mbtd_btn #(
    parameter int TIME_WIDTH = mbtd_pkg::TIME_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_sample,
    input  logic [TIME_WIDTH-1:0]          i_now,
    input  logic [mbtd_pkg::DEB_W-1:0]     i_debounce,
    output mbtd_pkg::t_btn_status          o_status,
    output logic [TIME_WIDTH-1:0]          o_press_next
);

    logic                  r_stable;
    logic                  r_cand;
    logic [TIME_WIDTH-1:0] r_change;
    logic [TIME_WIDTH-1:0] r_press;

    logic                  n_stable;
    logic                  n_cand;
    logic [TIME_WIDTH-1:0] n_change;
    logic [TIME_WIDTH-1:0] n_press;

    logic [TIME_WIDTH-1:0] elapsed;
    logic                  settle;

    always_comb begin
        elapsed  = i_now - r_change;
        settle   = (i_sample == r_cand) && (i_sample != r_stable)
                   && (elapsed >= TIME_WIDTH'(i_debounce));
        n_cand   = i_sample;
        n_change = (i_sample != r_cand) ? i_now : r_change;
        n_stable = settle ? i_sample : r_stable;
        n_press  = r_press;
        if (settle) begin
            n_press = i_sample ? i_now : '0;
        end
        o_status.stable_next = n_stable;
        o_status.pressed     = settle & i_sample;
        o_status.released    = settle & ~i_sample;
        o_press_next         = n_press;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable <= 1'b0;
            r_cand   <= 1'b0;
            r_change <= '0;
            r_press  <= '0;
        end else if (i_en) begin
            r_stable <= n_stable;
            r_cand   <= n_cand;
            r_change <= n_change;
            r_press  <= n_press;
        end
    end

endmodule

// ===== sv/mbtd_held.sv =====
// ----------------------------------------------------------------------------
// mbtd_held
// Held-time lookup: selects one button and measures time since its press.
// ----------------------------------------------------------------------------
module mbtd_held #(
    parameter int TIME_WIDTH = mbtd_pkg::TIME_WIDTH_DEF
) (
    input  logic [mbtd_pkg::SEL_W-1:0]       i_sel,
    input  logic [mbtd_pkg::NUM_BUTTONS-1:0] i_stable,
    input  logic [TIME_WIDTH-1:0]            i_press [mbtd_pkg::NUM_BUTTONS],
    input  logic [TIME_WIDTH-1:0]            i_now,
    output logic [mbtd_pkg::HELD_W-1:0]      o_held
);

    logic                         hit;
    logic [TIME_WIDTH-1:0]        press;
    logic [TIME_WIDTH-1:0]        diff;
    logic [TIME_WIDTH+mbtd_pkg::HELD_W-1:0] diff_wide;

    always_comb begin
        hit   = 1'b0;
        press = '0;
        for (int i = 0; i < mbtd_pkg::NUM_BUTTONS; i++) begin
            if (i_sel == mbtd_pkg::SEL_W'(i)) begin
                hit   = i_stable[i];
                press = i_press[i];
            end
        end
        diff      = i_now - press;
        diff_wide = {{mbtd_pkg::HELD_W{1'b0}}, diff};
        // a press stamped at time zero reads as no press
        o_held    = (hit && (press != '0)) ? diff_wide[mbtd_pkg::HELD_W-1:0] : '0;
    end

endmodule

// ===== sv/multi_button_time_debouncer_core.sv =====
// ----------------------------------------------------------------------------
// multi_button_time_debouncer_core
// Nine-button debouncer with press/release pulses and held-time readout.
// ----------------------------------------------------------------------------
// Each transaction is one poll. The block takes one poll per clock while the
// output is not stalled: the poll lands in an input register, the nine button
// cells and the held-time lookup settle in one pass, and the result is captured
// in an output register while the cell state updates at the same edge, so the
// next poll already sees it. A stalled output holds the result and backs up
// through the input register. debounce_ms sits at APB byte address 0 (reset
// 12); write it only while the block is idle.
// ----------------------------------------------------------------------------
module multi_button_time_debouncer_core #(
    parameter int TIME_WIDTH = mbtd_pkg::TIME_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mbtd_pkg::ADDR_W-1:0]       paddr,
    input  logic [mbtd_pkg::PDATA_W-1:0]      pwdata,
    output logic [mbtd_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready,

    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [mbtd_pkg::NUM_REG_BITS-1:0] i_raw_byte,
    input  logic                              i_boot_level,
    input  logic [mbtd_pkg::NOW_W-1:0]        i_now_ms,
    input  logic [mbtd_pkg::SEL_W-1:0]        i_held_select,

    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [mbtd_pkg::NUM_REG_BITS-1:0] o_raw_inverted,
    output logic [mbtd_pkg::NUM_BUTTONS-1:0]  o_stable_mask,
    output logic [mbtd_pkg::NUM_BUTTONS-1:0]  o_pressed_mask,
    output logic [mbtd_pkg::NUM_BUTTONS-1:0]  o_released_mask,
    output logic                              o_any_down,
    output logic [mbtd_pkg::HELD_W-1:0]       o_held_ms
);

    localparam int NB = mbtd_pkg::NUM_BUTTONS;

    // configuration
    logic [mbtd_pkg::DEB_W-1:0] r_debounce;

    // input register
    logic                              r_s1_valid;
    logic [mbtd_pkg::NUM_REG_BITS-1:0] r_raw;
    logic                              r_boot;
    logic [mbtd_pkg::NOW_W-1:0]        r_now;
    logic [mbtd_pkg::SEL_W-1:0]        r_sel;

    // output register
    logic                              r_out_valid;
    logic [mbtd_pkg::NUM_REG_BITS-1:0] r_inv;
    logic [NB-1:0]                     r_stable_mask;
    logic [NB-1:0]                     r_pressed_mask;
    logic [NB-1:0]                     r_released_mask;
    logic                              r_any_down;
    logic [mbtd_pkg::HELD_W-1:0]       r_held;

    logic                              out_load;
    logic                              in_take;
    logic [mbtd_pkg::NUM_REG_BITS-1:0] inv;
    logic [NB-1:0]                     sample;
    logic [TIME_WIDTH+mbtd_pkg::NOW_W-1:0] now_wide;
    logic [TIME_WIDTH-1:0]             now_t;
    mbtd_pkg::t_btn_status             status [NB];
    logic [TIME_WIDTH-1:0]             press_next [NB];
    logic [NB-1:0]                     n_stable_mask;
    logic [NB-1:0]                     n_pressed_mask;
    logic [NB-1:0]                     n_released_mask;
    logic [mbtd_pkg::HELD_W-1:0]       n_held;

    // APB
    assign pready = 1'b1;
    assign prdata = (paddr == mbtd_pkg::ADDR_DEBOUNCE)
                  ? mbtd_pkg::PDATA_W'(r_debounce) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= mbtd_pkg::DEBOUNCE_RESET;
        end else if (psel && penable && pwrite && pready
                     && (paddr == mbtd_pkg::ADDR_DEBOUNCE)) begin
            r_debounce <= pwdata[mbtd_pkg::DEB_W-1:0];
        end
    end

    // handshake: stage 1 moves whenever the output register is free or draining
    assign out_load   = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || out_load;
    assign in_take    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_raw  <= i_raw_byte;
            r_boot <= i_boot_level;
            r_now  <= i_now_ms;
            r_sel  <= i_held_select;
        end
    end

    // sample decode and time alignment
    always_comb begin
        inv      = ~r_raw;
        now_wide = {{TIME_WIDTH{1'b0}}, r_now};
        now_t    = now_wide[TIME_WIDTH-1:0];
    end

    for (genvar g = 0; g < NB; g++) begin : g_btn
        if (g == mbtd_pkg::BOOT_INDEX) begin : g_boot
            assign sample[g] = ~r_boot;
        end else begin : g_reg
            assign sample[g] = inv[mbtd_pkg::BIT_OF_BUTTON[g]];
        end

        mbtd_btn #(
            .TIME_WIDTH (TIME_WIDTH)
        ) u_btn (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_en         (out_load),
            .i_sample     (sample[g]),
            .i_now        (now_t),
            .i_debounce   (r_debounce),
            .o_status     (status[g]),
            .o_press_next (press_next[g])
        );

        assign n_stable_mask[g]   = status[g].stable_next;
        assign n_pressed_mask[g]  = status[g].pressed;
        assign n_released_mask[g] = status[g].released;
    end

    mbtd_held #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_held (
        .i_sel    (r_sel),
        .i_stable (n_stable_mask),
        .i_press  (press_next),
        .i_now    (now_t),
        .o_held   (n_held)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || i_out_ready) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_inv           <= inv;
            r_stable_mask   <= n_stable_mask;
            r_pressed_mask  <= n_pressed_mask;
            r_released_mask <= n_released_mask;
            r_any_down      <= |n_stable_mask[mbtd_pkg::ANY_DOWN_COUNT-1:0];
            r_held          <= n_held;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_raw_inverted  = r_inv;
    assign o_stable_mask   = r_stable_mask;
    assign o_pressed_mask  = r_pressed_mask;
    assign o_released_mask = r_released_mask;
    assign o_any_down      = r_any_down;
    assign o_held_ms       = r_held;

`ifndef ASSERT_OFF
    a_edge_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_pressed_mask & o_released_mask) == '0))
        else $error("press and release pulse on the same button");

    a_press_is_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_pressed_mask & ~o_stable_mask) == '0))
        else $error("press pulse on a button that is not stably down");

    a_release_is_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_released_mask & o_stable_mask) == '0))
        else $error("release pulse on a button that is still down");

    a_any_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_any_down == (|o_stable_mask[mbtd_pkg::ANY_DOWN_COUNT-1:0])))
        else $error("any_down disagrees with stable mask");
`endif

endmodule
